### rtl/cse_pkg.sv
// Shared types, widths and the reciprocal table of the cosh series evaluator.
`timescale 1ns / 1ps
package cse_pkg;

   localparam int X_W         = 16;   // signed Q3.12 argument
   localparam int MAG_W       = 16;   // magnitude of the argument
   localparam int X2_W        = 31;   // x squared, unsigned Q7.24, at most 2^30
   localparam int RECIP_W     = 32;   // reciprocal, unsigned Q0.32
   localparam int FACTOR_W    = 30;   // x^2 / ((2n-1)(2n)), unsigned Q6.24
   localparam int TERM_W      = 31;   // term and sum, unsigned Q11.20
   localparam int PROD_W      = TERM_W + FACTOR_W;
   localparam int THR_W       = 21;
   localparam int COUNT_W     = 6;
   localparam int RECIP_DEPTH = 64;
   localparam int RECIP_IDX_W = 6;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 40;

   localparam logic [THR_W-1:0]  THR_RESET = 21'd10;
   localparam logic [TERM_W-1:0] ONE_Q20   = 31'h0010_0000;
   localparam logic [TERM_W-1:0] SAT_MAX   = 31'h7FFF_FFFF;

   localparam logic [63:0] P32 = 64'd4294967296;

   // Entry n-1 holds round(2^32 / ((2n-1)(2n))).
   localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
      32'((P32 + 64'd1) / 64'd2),           32'((P32 + 64'd6) / 64'd12),
      32'((P32 + 64'd15) / 64'd30),         32'((P32 + 64'd28) / 64'd56),
      32'((P32 + 64'd45) / 64'd90),         32'((P32 + 64'd66) / 64'd132),
      32'((P32 + 64'd91) / 64'd182),        32'((P32 + 64'd120) / 64'd240),
      32'((P32 + 64'd153) / 64'd306),       32'((P32 + 64'd190) / 64'd380),
      32'((P32 + 64'd231) / 64'd462),       32'((P32 + 64'd276) / 64'd552),
      32'((P32 + 64'd325) / 64'd650),       32'((P32 + 64'd378) / 64'd756),
      32'((P32 + 64'd435) / 64'd870),       32'((P32 + 64'd496) / 64'd992),
      32'((P32 + 64'd561) / 64'd1122),      32'((P32 + 64'd630) / 64'd1260),
      32'((P32 + 64'd703) / 64'd1406),      32'((P32 + 64'd780) / 64'd1560),
      32'((P32 + 64'd861) / 64'd1722),      32'((P32 + 64'd946) / 64'd1892),
      32'((P32 + 64'd1035) / 64'd2070),     32'((P32 + 64'd1128) / 64'd2256),
      32'((P32 + 64'd1225) / 64'd2450),     32'((P32 + 64'd1326) / 64'd2652),
      32'((P32 + 64'd1431) / 64'd2862),     32'((P32 + 64'd1540) / 64'd3080),
      32'((P32 + 64'd1653) / 64'd3306),     32'((P32 + 64'd1770) / 64'd3540),
      32'((P32 + 64'd1891) / 64'd3782),     32'((P32 + 64'd2016) / 64'd4032),
      32'((P32 + 64'd2145) / 64'd4290),     32'((P32 + 64'd2278) / 64'd4556),
      32'((P32 + 64'd2415) / 64'd4830),     32'((P32 + 64'd2556) / 64'd5112),
      32'((P32 + 64'd2701) / 64'd5402),     32'((P32 + 64'd2850) / 64'd5700),
      32'((P32 + 64'd3003) / 64'd6006),     32'((P32 + 64'd3160) / 64'd6320),
      32'((P32 + 64'd3321) / 64'd6642),     32'((P32 + 64'd3486) / 64'd6972),
      32'((P32 + 64'd3655) / 64'd7310),     32'((P32 + 64'd3828) / 64'd7656),
      32'((P32 + 64'd4005) / 64'd8010),     32'((P32 + 64'd4186) / 64'd8372),
      32'((P32 + 64'd4371) / 64'd8742),     32'((P32 + 64'd4560) / 64'd9120),
      32'((P32 + 64'd4753) / 64'd9506),     32'((P32 + 64'd4950) / 64'd9900),
      32'((P32 + 64'd5151) / 64'd10302),    32'((P32 + 64'd5356) / 64'd10712),
      32'((P32 + 64'd5565) / 64'd11130),    32'((P32 + 64'd5778) / 64'd11556),
      32'((P32 + 64'd5995) / 64'd11990),    32'((P32 + 64'd6216) / 64'd12432),
      32'((P32 + 64'd6441) / 64'd12882),    32'((P32 + 64'd6670) / 64'd13340),
      32'((P32 + 64'd6903) / 64'd13806),    32'((P32 + 64'd7140) / 64'd14280),
      32'((P32 + 64'd7381) / 64'd14762),    32'((P32 + 64'd7626) / 64'd15252),
      32'((P32 + 64'd7875) / 64'd15750),    32'((P32 + 64'd8128) / 64'd16256)
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FACTOR,
      ST_MUL,
      ST_ROUND,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic init;         // capture x^2, restart sum, term and count
      logic calc_factor;  // load factor register from the reciprocal table
      logic factor_next;  // index the table with count+1 instead of count
      logic mul_term;     // load product of term and factor
      logic round_term;   // round and saturate the product into the term
      logic step;         // add term to sum, advance count
      logic set_limit;    // mark the term limit as the reason to stop
      logic load_result;  // move the finished result into the output register
   } cmd_type;

   typedef struct packed {
      logic term_below;   // current term is below the threshold
      logic count_at_max; // term count has reached its limit
      logic rsp_free;     // output register can take a result this cycle
   } sts_type;

endpackage

### rtl/cse_ctrl.sv
// Sequencer of the cosh series evaluator: walks each argument through the term loop.
`timescale 1ns / 1ps
module cse_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  cse_pkg::sts_type sts,
   output cse_pkg::cmd_type cmd
);
   import cse_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_FACTOR;
            end
         end
         ST_FACTOR: state_in = ST_MUL;
         ST_MUL:    state_in = ST_ROUND;
         ST_ROUND:  state_in = ST_CHECK;
         ST_CHECK: begin
            if (sts.term_below || sts.count_at_max) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_ROUND;
            end
         end
         ST_FINISH: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.init   = req_tvalid;
         end
         ST_FACTOR: cmd.calc_factor = 1'b1;
         ST_MUL:    cmd.mul_term = 1'b1;
         ST_ROUND: begin
            cmd.round_term  = 1'b1;
            cmd.calc_factor = 1'b1;
            cmd.factor_next = 1'b1;
         end
         ST_CHECK: begin
            // launch the next product speculatively; dropped when the loop ends
            cmd.mul_term  = 1'b1;
            cmd.step      = !sts.term_below && !sts.count_at_max;
            cmd.set_limit = !sts.term_below && sts.count_at_max;
         end
         ST_FINISH: cmd.load_result = sts.rsp_free;
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/cse_datapath.sv
// Datapath of the cosh series evaluator: square, factor, term, sum and result registers.
`timescale 1ns / 1ps
module cse_datapath #(
   parameter int MAX_TERMS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  cse_pkg::cmd_type                  cmd,
   output cse_pkg::sts_type                  sts,
   input  logic [cse_pkg::X_W-1:0]           req_x,
   input  logic                              csr_write,
   input  logic [cse_pkg::THR_W-1:0]         csr_data,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [cse_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser
);
   import cse_pkg::*;

   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TERMS);

   logic [THR_W-1:0]    thr_ff;
   logic [X2_W-1:0]     x2_ff;
   logic [X2_W-1:0]     x2_in;
   logic [MAG_W-1:0]    mag;
   logic [2*MAG_W-1:0]  mag_sq;
   logic [FACTOR_W-1:0] factor_ff;
   logic [FACTOR_W-1:0] factor_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [TERM_W-1:0]   term_ff;
   logic [TERM_W-1:0]   term_in;
   logic [TERM_W-1:0]   sum_ff;
   logic [TERM_W-1:0]   sum_in;
   logic [CNT_W-1:0]    count_ff;
   logic                limit_ff;
   logic                rsp_valid_ff;
   logic [TERM_W-1:0]   rsp_value_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_limit_ff;

   logic [RECIP_IDX_W-1:0]      fac_idx;
   logic [X2_W+RECIP_W-1:0]     fac_prod;
   logic [63:0]                 fac_rnd;
   logic [PROD_W:0]             term_rnd;
   logic [PROD_W-24:0]          term_shift;
   logic [TERM_W:0]             sum_add;

   // x^2 from the two's complement magnitude; the most negative code maps to 2^15
   assign mag    = req_x[X_W-1] ? MAG_W'(-req_x) : req_x;
   assign mag_sq = mag * mag;
   assign x2_in  = mag_sq[X2_W-1:0];

   // factor = round(x^2 * recip >> 32)
   assign fac_idx   = cmd.factor_next ? RECIP_IDX_W'(count_ff)
                                      : RECIP_IDX_W'(count_ff - 1'b1);
   assign fac_prod  = x2_ff * RECIP_TABLE[fac_idx];
   assign fac_rnd   = 64'(fac_prod) + (64'd1 << 31);
   assign factor_in = fac_rnd[32+FACTOR_W-1:32];

   // term = sat(round(term * factor >> 24))
   assign prod_in    = term_ff * factor_ff;
   assign term_rnd   = (PROD_W+1)'(prod_ff) + ((PROD_W+1)'(1) << 23);
   assign term_shift = term_rnd[PROD_W:24];
   assign term_in    = (|term_shift[PROD_W-24:TERM_W]) ? SAT_MAX : term_shift[TERM_W-1:0];

   assign sum_add = {1'b0, sum_ff} + {1'b0, term_ff};
   assign sum_in  = sum_add[TERM_W] ? SAT_MAX : sum_add[TERM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_write) begin
         thr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= 1'b0;
      end else if (cmd.init) begin
         count_ff <= CNT_W'(1);
         limit_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            count_ff <= count_ff + 1'b1;
         end
         if (cmd.set_limit) begin
            limit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         x2_ff   <= x2_in;
         term_ff <= ONE_Q20;
         sum_ff  <= ONE_Q20;
      end else begin
         if (cmd.round_term) begin
            term_ff <= term_in;
         end
         if (cmd.step) begin
            sum_ff <= sum_in;
         end
      end
      if (cmd.calc_factor) begin
         factor_ff <= factor_in;
      end
      if (cmd.mul_term) begin
         prod_ff <= prod_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_value_ff <= sum_ff;
         rsp_count_ff <= COUNT_W'(count_ff);
         rsp_limit_ff <= limit_ff;
      end
   end

   assign sts.term_below   = term_ff < TERM_W'(thr_ff);
   assign sts.count_at_max = count_ff >= CNT_MAX;
   assign sts.rsp_free     = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W-TERM_W-COUNT_W)'(0), rsp_count_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_limit_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over one not yet transferred");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("term count beyond limit");

   a_limit_at_max: assert property (@(posedge clock) disable iff (reset)
      limit_ff |-> (count_ff == CNT_MAX))
      else $error("limit flag set below the term limit");

   a_step_above: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!sts.term_below && !sts.count_at_max))
      else $error("term added although the loop should stop");

   a_step_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.step |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("count did not advance on a summed term");
`endif

endmodule

### rtl/cosh_series_evaluator_core.sv
// Top level of the cosh series evaluator: stream ports, sequencer and datapath.
// After the req transfer an argument passes the factor, multiply, round/check
//   and finish states before rsp_tvalid, plus any wait while the previous
//   result stays in the output register. One argument at a time; every term
//   costs one pass through the factor multiplier and the term multiplier.
// Reset: synchronous, active high; clears the sequencer, the output valid and
//   sets stop_threshold to 10 (about 1e-5 in Q11.20).
`timescale 1ns / 1ps
module cosh_series_evaluator_core #(
   parameter int MAX_TERMS = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // x_value [15:0], signed Q3.12
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cse_pkg::REQ_DATA_W-1:0]   req_tdata,
   // cosh_value [30:0] unsigned Q11.20, term_count [36:31], zero fill [39:37]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cse_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // limit_hit [0]
   output logic                             rsp_tuser,
   // stop_threshold write, unsigned Q1.20
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cse_pkg::THR_W-1:0]        csr_data
);
   import cse_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Threshold writes are always taken; the user must write them only while the block is idle (not enforced here).
   assign csr_ready = 1'b1;

   // The sequencer takes an argument only in idle and walks it through:
   // factor lookup, first product, then round/check pairs until a term drops
   // below the threshold or the count limit is reached. The finished sum waits
   // in its state until the output register is free.
   cse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Hold threshold, x^2, factor, product, term, sum and the output register.
   cse_datapath #(
      .MAX_TERMS (MAX_TERMS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_x      (req_tdata[X_W-1:0]),
      .csr_write  (csr_valid & csr_ready),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
